// ----- hw/rtl/sobfc_pkg.sv -----
`default_nettype none

package sobfc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 17;
    localparam int PROD_W     = GAIN_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int POLE_SHIFT = 15;
    localparam int BQ_SHIFT   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLES,
        REG_POLE_FB,
        REG_POLE_GAIN,
        REG_BQ_FB1,
        REG_BQ_FB2,
        REG_BQ_FF0,
        REG_BQ_FF1,
        REG_BQ_FF2
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]                enables;
        logic signed [COEF_W-1:0]  pole_fb;
        logic signed [GAIN_W-1:0]  pole_gain;
        logic signed [COEF_W-1:0]  bq_fb1;
        logic signed [COEF_W-1:0]  bq_fb2;
        logic signed [COEF_W-1:0]  bq_ff0;
        logic signed [COEF_W-1:0]  bq_ff1;
        logic signed [COEF_W-1:0]  bq_ff2;
    } t_coef;

    typedef struct packed {
        logic start;
        logic clr_pole;
        logic clr_bq;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/sobfc_if.sv -----
`default_nettype none

interface sobfc_in_if;
    import sobfc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, left_in, right_in, input ready);
    modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface sobfc_out_if;
    import sobfc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sobfc_lane.sv -----
`default_nettype none

module sobfc_lane
    import sobfc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_coef                      i_coef,
    input  wire t_lane_ctl                  i_ctl,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_done,
    output logic signed [SAMPLE_W-1:0]      o_result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_GAIN,
        ST_P_FB,
        ST_P_END,
        ST_B_FF0,
        ST_B_FF1,
        ST_B_FF2,
        ST_B_FB1,
        ST_B_FB2,
        ST_B_END,
        ST_DONE
    } t_state;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SAMPLE_MIN);

    function automatic logic signed [SAMPLE_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > ACC_MAX) begin
            r = SAMPLE_W'(SAMPLE_MAX);
        end else if (v < ACC_MIN) begin
            r = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    t_state                     r_state;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_pole_y;
    logic signed [SAMPLE_W-1:0] r_x1;
    logic signed [SAMPLE_W-1:0] r_x2;
    logic signed [SAMPLE_W-1:0] r_y1;
    logic signed [SAMPLE_W-1:0] r_y2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    logic signed [GAIN_W-1:0]   w_a;
    logic signed [SAMPLE_W-1:0] w_b;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [SAMPLE_W-1:0] w_pole_y;
    logic signed [SAMPLE_W-1:0] w_bq_y;

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            ST_P_GAIN: begin w_a = i_coef.pole_gain;           w_b = r_x;      end
            ST_P_FB:   begin w_a = GAIN_W'(i_coef.pole_fb);    w_b = r_pole_y; end
            ST_B_FF0:  begin w_a = GAIN_W'(i_coef.bq_ff0);     w_b = r_x;      end
            ST_B_FF1:  begin w_a = GAIN_W'(i_coef.bq_ff1);     w_b = r_x1;     end
            ST_B_FF2:  begin w_a = GAIN_W'(i_coef.bq_ff2);     w_b = r_x2;     end
            ST_B_FB1:  begin w_a = GAIN_W'(i_coef.bq_fb1);     w_b = r_y1;     end
            ST_B_FB2:  begin w_a = GAIN_W'(i_coef.bq_fb2);     w_b = r_y2;     end
            default:   begin w_a = '0;                         w_b = '0;       end
        endcase
    end

    assign w_sum    = r_acc + ACC_W'(r_prod);
    assign w_pole_y = f_sat(w_sum >>> POLE_SHIFT);
    assign w_bq_y   = f_sat(w_sum >>> BQ_SHIFT);

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pole_y <= '0;
            r_x1     <= '0;
            r_x2     <= '0;
            r_y1     <= '0;
            r_y2     <= '0;
            r_acc    <= '0;
        end else begin
            if (i_ctl.clr_pole) begin
                r_pole_y <= '0;
            end
            if (i_ctl.clr_bq) begin
                r_x1 <= '0;
                r_x2 <= '0;
                r_y1 <= '0;
                r_y2 <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctl.start) begin
                        r_x <= i_sample;
                        if (i_coef.enables[0]) begin
                            r_state <= ST_P_GAIN;
                        end else if (i_coef.enables[1]) begin
                            r_state <= ST_B_FF0;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_P_GAIN: begin
                    r_acc   <= '0;
                    r_state <= ST_P_FB;
                end
                ST_P_FB: begin
                    r_acc   <= w_sum;
                    r_state <= ST_P_END;
                end
                ST_P_END: begin
                    r_x      <= w_pole_y;
                    r_pole_y <= w_pole_y;
                    r_state  <= i_coef.enables[1] ? ST_B_FF0 : ST_DONE;
                end
                ST_B_FF0: begin
                    r_acc   <= '0;
                    r_state <= ST_B_FF1;
                end
                ST_B_FF1: begin
                    r_acc   <= w_sum;
                    r_state <= ST_B_FF2;
                end
                ST_B_FF2: begin
                    r_acc   <= w_sum;
                    r_state <= ST_B_FB1;
                end
                ST_B_FB1: begin
                    r_acc   <= w_sum;
                    r_state <= ST_B_FB2;
                end
                ST_B_FB2: begin
                    r_acc   <= w_sum;
                    r_state <= ST_B_END;
                end
                ST_B_END: begin
                    r_x2    <= r_x1;
                    r_x1    <= r_x;
                    r_y2    <= r_y1;
                    r_y1    <= w_bq_y;
                    r_x     <= w_bq_y;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == ST_DONE);
    assign o_result = r_x;

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_onepole_biquad_filter_chain_core.sv -----
// Channel  | Dir | Handshake           | Payload
// i_in     | in  | valid / ready       | left_in, right_in (signed 16)
// o_out    | out | valid / ready       | left_out, right_out (signed 16)
// i_cfg_*  | in  | write enable only   | index 3 bits, data 17 bits
//
// A stereo pair passes through the enabled stages of each lane, from transfer
// in to result valid. The single multiplier in each lane steps through up to
// seven products, one product per cycle, then each stage is saturated and the
// lanes hand over. The next pair is taken the cycle after the lanes hand over.
// Reset is synchronous and active low: coefficients go to passthrough and all
// history is cleared. A stalled output holds its pair in the output register.

`default_nettype none

module stereo_onepole_biquad_filter_chain_core
    import sobfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sobfc_in_if.sink                   i_in,
    sobfc_out_if.source                o_out
);

    t_coef                      r_coef;
    logic                       r_busy;
    logic                       r_have;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_left;
    logic signed [SAMPLE_W-1:0] r_out_right;

    t_lane_ctl                  w_ctl;
    logic                       w_done_l;
    logic                       w_done_r;
    logic signed [SAMPLE_W-1:0] w_res_l;
    logic signed [SAMPLE_W-1:0] w_res_r;
    logic                       w_have;
    logic                       w_load;
    logic                       w_accept;

    // input transfer only when both lanes have handed over
    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;

    // clear a stage's history whenever its enable is written low
    always_comb begin
        w_ctl.start    = w_accept;
        w_ctl.clr_pole = i_cfg_we && (t_reg_idx'(i_cfg_idx) == REG_ENABLES) && !i_cfg_data[0];
        w_ctl.clr_bq   = i_cfg_we && (t_reg_idx'(i_cfg_idx) == REG_ENABLES) && !i_cfg_data[1];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.enables   <= '0;
            r_coef.pole_fb   <= '0;
            r_coef.pole_gain <= 17'sh08000;
            r_coef.bq_fb1    <= '0;
            r_coef.bq_fb2    <= '0;
            r_coef.bq_ff0    <= 16'sh4000;
            r_coef.bq_ff1    <= '0;
            r_coef.bq_ff2    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ENABLES:   r_coef.enables   <= i_cfg_data[1:0];
                REG_POLE_FB:   r_coef.pole_fb   <= i_cfg_data[COEF_W-1:0];
                REG_POLE_GAIN: r_coef.pole_gain <= i_cfg_data[GAIN_W-1:0];
                REG_BQ_FB1:    r_coef.bq_fb1    <= i_cfg_data[COEF_W-1:0];
                REG_BQ_FB2:    r_coef.bq_fb2    <= i_cfg_data[COEF_W-1:0];
                REG_BQ_FF0:    r_coef.bq_ff0    <= i_cfg_data[COEF_W-1:0];
                REG_BQ_FF1:    r_coef.bq_ff1    <= i_cfg_data[COEF_W-1:0];
                REG_BQ_FF2:    r_coef.bq_ff2    <= i_cfg_data[COEF_W-1:0];
                default:       r_coef.enables   <= r_coef.enables;
            endcase
        end
    end

    // one lane per channel
    sobfc_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (r_coef),
        .i_ctl    (w_ctl),
        .i_sample (i_in.left_in),
        .o_done   (w_done_l),
        .o_result (w_res_l)
    );

    sobfc_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (r_coef),
        .i_ctl    (w_ctl),
        .i_sample (i_in.right_in),
        .o_done   (w_done_r),
        .o_result (w_res_r)
    );

    // merge: both lanes run in lockstep; hold the pair in the lanes until
    // the output register is free, then advance it
    assign w_have = r_have || (w_done_l && w_done_r);
    assign w_load = w_have && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            r_have <= w_have && !w_load;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_out_left  <= w_res_l;
            r_out_right <= w_res_r;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;

endmodule

`default_nettype wire

// ----- hw/rtl/sobfc_checker.sv -----
`default_nettype none

module sobfc_checker
    import sobfc_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [SAMPLE_W-1:0] i_out_left,
    input wire logic signed [SAMPLE_W-1:0] i_out_right
);

    // pairs taken in and not yet delivered
    logic [1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'((i_in_valid && i_in_ready) ? 1 : 0)
                             - 2'((i_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_left) && $stable(i_out_right))
        else $error("output pair changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a pair is in the lanes");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("output shown with no pair outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> r_pend <= 2'd1)
        else $error("ready with more than one pair outstanding");

endmodule

bind stereo_onepole_biquad_filter_chain_core sobfc_checker u_sobfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.left_out),
    .i_out_right (o_out.right_out)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import sobfc_pkg::*;

    localparam int HOLD_CYCLES   = 300;  // one long output back-pressure burst
    localparam int SETTLE_CYCLES = 24;   // longer than the slowest path (both stages on)
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_NS      = 4_000_000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Scoreboard: carries its own copy of the coefficients and per-lane filter
    // history, works out the filtered pair for every accepted input transfer
    // and compares output transfers against the oldest outstanding pair.
    class filter_scoreboard;
        logic [1:0]               enables;
        logic signed [COEF_W-1:0] pole_fb;
        logic signed [GAIN_W-1:0] pole_gain;
        logic signed [COEF_W-1:0] bq_fb1, bq_fb2, bq_ff0, bq_ff1, bq_ff2;
        t_sample                  pole_y1 [2];
        t_sample                  bq_x1 [2], bq_x2 [2], bq_y1 [2], bq_y2 [2];
        t_sample                  want_left [$], want_right [$];
        int                       mismatches;

        function new();
            enables    = '0;
            pole_fb    = '0;
            pole_gain  = GAIN_W'(32768);
            bq_fb1     = '0;
            bq_fb2     = '0;
            bq_ff0     = COEF_W'(16384);
            bq_ff1     = '0;
            bq_ff2     = '0;
            mismatches = 0;
            clear_pole();
            clear_biquad();
        endfunction

        function void clear_pole();
            pole_y1 = '{default: '0};
        endfunction

        function void clear_biquad();
            bq_x1 = '{default: '0};
            bq_x2 = '{default: '0};
            bq_y1 = '{default: '0};
            bq_y2 = '{default: '0};
        endfunction

        // 16-bit registers keep only their low 16 bits; a disabled stage drops its history
        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLES: begin
                    enables = data[1:0];
                    if (!enables[0]) clear_pole();
                    if (!enables[1]) clear_biquad();
                end
                REG_POLE_FB:   pole_fb   = data[COEF_W-1:0];
                REG_POLE_GAIN: pole_gain = data[GAIN_W-1:0];
                REG_BQ_FB1:    bq_fb1    = data[COEF_W-1:0];
                REG_BQ_FB2:    bq_fb2    = data[COEF_W-1:0];
                REG_BQ_FF0:    bq_ff0    = data[COEF_W-1:0];
                REG_BQ_FF1:    bq_ff1    = data[COEF_W-1:0];
                REG_BQ_FF2:    bq_ff2    = data[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function t_sample clamp_sample(longint v);
            if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
            if (v < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
            return SAMPLE_W'(v);
        endfunction

        // Arithmetic right shift of a full-width sum floors, as the block must
        function t_sample filter_lane(int ch, t_sample sample);
            longint  acc;
            t_sample x;
            t_sample y;
            x = sample;
            if (enables[0]) begin
                acc = longint'(pole_gain) * longint'(x)
                    + longint'(pole_fb) * longint'(pole_y1[ch]);
                x = clamp_sample(acc >>> POLE_SHIFT);
                pole_y1[ch] = x;
            end
            if (enables[1]) begin
                acc = longint'(bq_ff0) * longint'(x)
                    + longint'(bq_ff1) * longint'(bq_x1[ch])
                    + longint'(bq_ff2) * longint'(bq_x2[ch])
                    + longint'(bq_fb1) * longint'(bq_y1[ch])
                    + longint'(bq_fb2) * longint'(bq_y2[ch]);
                y = clamp_sample(acc >>> BQ_SHIFT);
                bq_x2[ch] = bq_x1[ch];
                bq_x1[ch] = x;
                bq_y2[ch] = bq_y1[ch];
                bq_y1[ch] = y;
                x = y;
            end
            return x;
        endfunction

        function void note_input(t_sample left, t_sample right);
            want_left.push_back(filter_lane(0, left));
            want_right.push_back(filter_lane(1, right));
        endfunction

        function void report_lane(string lane, t_sample want, t_sample got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("error: %s sample expected %0d, got %0d", lane, want, got);
        endfunction

        function void check_result(t_sample left, t_sample right);
            t_sample wl;
            t_sample wr;
            if (want_left.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("error: output pair %0d / %0d with nothing outstanding",
                             left, right);
                return;
            end
            wl = want_left.pop_front();
            wr = want_right.pop_front();
            if (left !== wl) report_lane("left", wl, left);
            if (right !== wr) report_lane("right", wr, right);
        endfunction

        function int pending();
            return want_left.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    t_reg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Idling switches and the back-pressure burst request, all owned by the
    // stimulus process and updated at clock edges
    logic tx_idle_on;
    logic rx_idle_on;
    logic burst_req;
    int   stall_left;
    int   burst_left;

    filter_scoreboard sb = new();

    sobfc_in_if  in_if ();
    sobfc_out_if out_if ();

    stereo_onepole_biquad_filter_chain_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic int tx_gap();
        if (!tx_idle_on) return 0;
        if ($urandom_range(0, 99) < 60) return 0;
        return gap_length();
    endfunction

    // Sample mix: full-scale noise, the rails, and small values near zero
    function automatic t_sample rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       return SAMPLE_W'(SAMPLE_MIN);
                1:       return SAMPLE_W'(SAMPLE_MAX);
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 30) return SAMPLE_W'($urandom_range(0, 1023) - 512);
        return SAMPLE_W'($urandom);
    endfunction

    // Output side: sample each transfer before the edge's updates land, then
    // pick ready for the next cycle. The one-off burst holds ready low so the
    // block fills and stalls its input.
    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready)
            sb.check_result(out_if.left_out, out_if.right_out);
        if (burst_req && burst_left > 0) begin
            out_if.ready <= 1'b0;
            burst_left   <= burst_left - 1;
        end else if (!rx_idle_on) begin
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            out_if.ready <= 1'b0;
            stall_left   <= gap_length() - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Offer one pair and hold it until the transfer; valid stays high on exit
    // so a back-to-back pair follows without a bubble
    task automatic send_pair(input t_sample left, input t_sample right);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.left_in  <= left;
        in_if.right_in <= right;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(left, right);
    endtask

    // Drop valid, wait for every outstanding pair, then let the lanes settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write enable is left high; the caller lowers it after the last write
    task automatic cfg_write(input t_reg_idx idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        sb.write_reg(idx, CFG_DATA_W'(value));
    endtask

    // Full-range coefficients saturate quickly; the tamer set keeps the
    // filters ringing so the history paths see real traffic
    task automatic randomize_config();
        bit tame;
        tame = $urandom_range(0, 1);
        cfg_write(REG_ENABLES, ($urandom & 32'h1fffc) | $urandom_range(0, 3));
        cfg_write(REG_POLE_FB, tame ? $urandom_range(0, 32000) : $urandom);
        cfg_write(REG_POLE_GAIN, tame ? $urandom_range(0, 32768) : $urandom);
        cfg_write(REG_BQ_FB1, tame ? $urandom_range(8000, 26000) : $urandom);
        cfg_write(REG_BQ_FB2, tame ? -$urandom_range(6000, 15000) : $urandom);
        cfg_write(REG_BQ_FF0, tame ? $urandom_range(0, 8192) - 4096 : $urandom);
        cfg_write(REG_BQ_FF1, tame ? $urandom_range(0, 8192) - 4096 : $urandom);
        cfg_write(REG_BQ_FF2, tame ? $urandom_range(0, 8192) - 4096 : $urandom);
        cfg_we <= 1'b0;
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.left_in  = '0;
        in_if.right_in = '0;
        out_if.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_ENABLES;
        cfg_data       = '0;
        rst_n          = 1'b0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        burst_req      = 1'b0;
        stall_left     = 0;
        burst_left     = HOLD_CYCLES;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: both stages off, pairs pass straight through
        send_pair(SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX));
        send_pair(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));
        send_pair('0, '1);

        // One-pole at unity gain with near-unity feedback: drive into the rails
        wait_idle();
        cfg_write(REG_POLE_FB, 32767);
        cfg_write(REG_ENABLES, 1);
        cfg_we <= 1'b0;
        repeat (3) send_pair(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));

        // Most negative gain and feedback; re-enable without losing history
        wait_idle();
        cfg_write(REG_POLE_GAIN, -65536);
        cfg_write(REG_POLE_FB, -32768);
        cfg_write(REG_ENABLES, 1);
        cfg_we <= 1'b0;
        send_pair(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));
        send_pair(SAMPLE_W'(SAMPLE_MIN), 16'sd1);

        // Biquad alone at extreme coefficients; the one-pole history is cleared
        wait_idle();
        cfg_write(REG_BQ_FF0, 32767);
        cfg_write(REG_BQ_FF1, -32768);
        cfg_write(REG_BQ_FF2, 32767);
        cfg_write(REG_BQ_FB1, 32767);
        cfg_write(REG_BQ_FB2, -32768);
        cfg_write(REG_ENABLES, 2);
        cfg_we <= 1'b0;
        send_pair(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));
        send_pair(16'sd1, -16'sd1);
        send_pair(SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX));
        send_pair('0, '0);

        // Both stages chained; biquad history carries over from above
        wait_idle();
        cfg_write(REG_POLE_GAIN, 32768);
        cfg_write(REG_POLE_FB, 16384);
        cfg_write(REG_BQ_FF0, 16384);
        cfg_write(REG_BQ_FF1, 8192);
        cfg_write(REG_BQ_FF2, -8192);
        cfg_write(REG_BQ_FB1, 8192);
        cfg_write(REG_BQ_FB2, -4096);
        cfg_write(REG_ENABLES, 3);
        cfg_we <= 1'b0;
        send_pair(16'sd12345, -16'sd12345);
        send_pair(-16'sd7, 16'sd7);
        send_pair(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN));
        send_pair('1, '1);

        // Disable both to flush history, with junk in the unused enable bits,
        // then come back on with a gain of minus one LSB
        wait_idle();
        cfg_write(REG_ENABLES, 32'h1fffc);
        cfg_write(REG_POLE_GAIN, 32'h1ffff);
        cfg_write(REG_ENABLES, 32'h0aaab);
        cfg_we <= 1'b0;
        send_pair(16'sd100, -16'sd100);
        send_pair(SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MIN));
        send_pair(SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));

        // Random phases: fresh coefficients each time, idling varied per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            randomize_config();
            tx_idle_on = (p % 4 != 1);
            rx_idle_on <= (p % 4 != 2);
            if (p == 3) burst_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // pause the input until the output has caught up completely
                if (p == 5 && n == PHASE_ITEMS / 2) wait_idle();
                send_pair(rand_sample(), rand_sample());
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("tb_top failed");
        $finish;
    end

endmodule
